// File: design/crq_pkg.sv
// shared types, constants and index helper for the reversible circular queue
package crq_pkg;

  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int OCC_W     = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [OCC_W-1:0]            occ_t;
  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam logic [1:0] ACT_ENQ = 2'd0;
  localparam logic [1:0] ACT_DEQ = 2'd1;
  localparam logic [1:0] ACT_REV = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_LEN   = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] word_in;
    logic [8:0]         prefix_len;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] word_out;
    logic [1:0]         status;
    logic [8:0]         occupancy_out;
  } out_item_t;

  // modular add on slot indices, operands below DEPTH
  function automatic idx_t wrap_add(input idx_t a, input idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W + 1)'(DEPTH)) begin
      s = s - (IDX_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// File: design/crq_ram.sv
// generic ram, one write port and two registered read ports
module crq_ram #(
  parameter int DEPTH_P = 256,
  parameter int WIDTH_P = 32
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
  input  logic [WIDTH_P-1:0]         wr_data,
  input  logic [$clog2(DEPTH_P)-1:0] rd_a_addr,
  input  logic [$clog2(DEPTH_P)-1:0] rd_b_addr,
  output logic [WIDTH_P-1:0]         rd_a_data,
  output logic [WIDTH_P-1:0]         rd_b_data
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// File: design/circular_queue_reverse_prefix.sv
// circular queue with in-place reverse of its first k entries, top level
//
//   channel | ports                         | payload
//   input   | in_valid / in_ready / in_data  | in_item_t  (action, word_in, prefix_len)
//   result  | out_valid / out_ready / out_data | out_item_t (word_out, status, occupancy_out)
//
// enqueue and rejected items go from idle to done, a dequeue passes a read state,
// and a reverse of k >= 2 swaps floor(k/2) pairs: each swap is a write of
// both entries through the single ram write port, with the next pair read in between.
// one item is in work at a time; intake reopens while a result still waits.
// reset clears state, head, tail, occupancy and out_valid only; storage is not cleared.
// a stalled result holds the block in its final state until out_ready.
module circular_queue_reverse_prefix
  import crq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_SWAP_RD,
    S_SWAP_WA,
    S_SWAP_WB,
    S_DONE
  } state_t;

  state_t             state_r;
  idx_t               head_r;
  idx_t               tail_r;
  occ_t               occ_r;
  idx_t               lo_r;
  idx_t               hi_r;
  idx_t               wb_addr_r;
  word_t              tmp_r;
  logic signed [31:0] res_word_r;
  logic [1:0]         res_status_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic  in_fire;
  logic  wr_en;
  idx_t  wr_addr;
  word_t wr_data;
  idx_t  rd_a_addr;
  idx_t  rd_b_addr;
  word_t rd_a_data;
  word_t rd_b_data;
  logic  q_full;
  logic  q_empty;
  logic  len_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign q_full  = (occ_r == OCC_W'(DEPTH));
  assign q_empty = (occ_r == '0);
  assign len_ok  = (in_data.prefix_len != 9'd0) &&
                   (32'(in_data.prefix_len) <= 32'(occ_r));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail_r;
    wr_data = WORD_BITS'(in_data.word_in);
    unique case (state_r)
      S_IDLE: begin
        wr_en = in_fire && (in_data.action == ACT_ENQ) && !q_full;
      end
      S_SWAP_WA: begin
        wr_en   = 1'b1;
        wr_addr = wrap_add(head_r, lo_r);
        wr_data = rd_b_data;
      end
      S_SWAP_WB: begin
        wr_en   = 1'b1;
        wr_addr = wb_addr_r;
        wr_data = tmp_r;
      end
      default: begin
      end
    endcase
  end

  // in idle port a reads the head for a possible dequeue
  assign rd_a_addr = (state_r == S_IDLE) ? head_r : wrap_add(head_r, lo_r);
  assign rd_b_addr = wrap_add(head_r, hi_r);

  crq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WORD_BITS)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in done the result register is reloaded instead
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_word_r <= '0;
            case (in_data.action)
              ACT_ENQ: begin
                state_r <= S_DONE;
                if (q_full) begin
                  res_status_r <= ST_FULL;
                end else begin
                  res_status_r <= ST_OK;
                  tail_r       <= wrap_add(tail_r, IDX_W'(1));
                  occ_r        <= occ_r + OCC_W'(1);
                end
              end
              ACT_DEQ: begin
                if (q_empty) begin
                  res_status_r <= ST_UNDERFLOW;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  head_r       <= wrap_add(head_r, IDX_W'(1));
                  occ_r        <= occ_r - OCC_W'(1);
                  state_r      <= S_DEQ;
                end
              end
              ACT_REV: begin
                if (!len_ok) begin
                  res_status_r <= ST_BAD_LEN;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  lo_r         <= '0;
                  hi_r         <= IDX_W'(in_data.prefix_len - 9'd1);
                  // a single entry needs no swap
                  state_r      <= (in_data.prefix_len > 9'd1) ? S_SWAP_RD : S_DONE;
                end
              end
              default: begin
                res_status_r <= ST_OK;
                state_r      <= S_DONE;
              end
            endcase
          end
        end
        S_DEQ: begin
          res_word_r <= 32'(rd_a_data);
          state_r    <= S_DONE;
        end
        S_SWAP_RD: begin
          state_r <= S_SWAP_WA;
        end
        S_SWAP_WA: begin
          tmp_r     <= rd_a_data;
          wb_addr_r <= wrap_add(head_r, hi_r);
          lo_r      <= lo_r + IDX_W'(1);
          hi_r      <= hi_r - IDX_W'(1);
          state_r   <= S_SWAP_WB;
        end
        S_SWAP_WB: begin
          // next pair is read while the old far entry is written
          state_r <= (lo_r < hi_r) ? S_SWAP_WA : S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.word_out        <= res_word_r;
            out_data_r.status          <= res_status_r;
            out_data_r.occupancy_out   <= 9'(occ_r);
            state_r                    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: dv/tb_circular_queue_reverse_prefix.sv
// testbench for the circular queue with front reverse: shadow queue, directed table, random traffic
`timescale 1ns / 100ps

module tb_circular_queue_reverse_prefix;
  import crq_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int N_DIR = 22;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_RESULT = 250;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t reply;
  } dir_row_t;

  localparam out_item_t NO_REPLY = '0;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // shadow copy of the queue contents and pointers
  word_t shadow_slot [DEPTH];
  idx_t  shadow_head = '0;
  idx_t  shadow_tail = '0;
  occ_t  shadow_count = '0;

  out_item_t queue_replies[$];
  int mismatch_count = 0;
  int sent_count = 0;
  int tx_idle_on = 1;

  // front extremes, error codes and reverses of even and odd length
  dir_row_t stim_table [N_DIR] = '{
    '{'{ACT_DEQ, 32'sd0, 9'd0}, 1'b1, '{32'sd0, ST_UNDERFLOW, 9'd0}},
    '{'{ACT_REV, 32'sd0, 9'd0}, 1'b1, '{32'sd0, ST_BAD_LEN, 9'd0}},
    '{'{ACT_REV, 32'sd0, 9'd1}, 1'b1, '{32'sd0, ST_BAD_LEN, 9'd0}},
    '{'{ACT_NONE, 32'h5A5A5A5A, 9'h1FF}, 1'b1, '{32'sd0, ST_OK, 9'd0}},
    '{'{ACT_ENQ, 32'h7FFFFFFF, 9'd0}, 1'b1, '{32'sd0, ST_OK, 9'd1}},
    '{'{ACT_ENQ, 32'h80000000, 9'd0}, 1'b1, '{32'sd0, ST_OK, 9'd2}},
    '{'{ACT_ENQ, 32'hFFFFFFFF, 9'd0}, 1'b1, '{32'sd0, ST_OK, 9'd3}},
    '{'{ACT_ENQ, 32'h00000000, 9'd0}, 1'b1, '{32'sd0, ST_OK, 9'd4}},
    '{'{ACT_ENQ, 32'h12345678, 9'h1FF}, 1'b1, '{32'sd0, ST_OK, 9'd5}},
    '{'{ACT_REV, 32'sd0, 9'd1}, 1'b1, '{32'sd0, ST_OK, 9'd5}},
    '{'{ACT_REV, 32'sd0, 9'd6}, 1'b1, '{32'sd0, ST_BAD_LEN, 9'd5}},
    '{'{ACT_REV, 32'sd0, 9'd256}, 1'b1, '{32'sd0, ST_BAD_LEN, 9'd5}},
    '{'{ACT_REV, 32'hFFFFFFFF, 9'h1FF}, 1'b1, '{32'sd0, ST_BAD_LEN, 9'd5}},
    '{'{ACT_REV, 32'sd0, 9'd5}, 1'b0, NO_REPLY},
    '{'{ACT_DEQ, 32'hDEADBEEF, 9'd3}, 1'b0, NO_REPLY},
    '{'{ACT_REV, 32'sd0, 9'd4}, 1'b0, NO_REPLY},
    '{'{ACT_REV, 32'sd0, 9'd3}, 1'b0, NO_REPLY},
    '{'{ACT_DEQ, 32'sd0, 9'd0}, 1'b0, NO_REPLY},
    '{'{ACT_DEQ, 32'sd0, 9'd0}, 1'b0, NO_REPLY},
    '{'{ACT_DEQ, 32'sd0, 9'd0}, 1'b0, NO_REPLY},
    '{'{ACT_DEQ, 32'sd0, 9'd0}, 1'b0, NO_REPLY},
    '{'{ACT_DEQ, 32'sd0, 9'd0}, 1'b1, '{32'sd0, ST_UNDERFLOW, 9'd0}}
  };

  circular_queue_reverse_prefix dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one action to the shadow queue and returns the reply it gives
  function automatic out_item_t apply_action(input in_item_t it);
    out_item_t r;
    int lo;
    int hi;
    idx_t a;
    idx_t b;
    word_t t;
    r = '0;
    r.status = ST_OK;
    case (it.action)
      ACT_ENQ: begin
        if (shadow_count == occ_t'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          shadow_slot[shadow_tail] = it.word_in;
          shadow_tail = shadow_tail + idx_t'(1);
          shadow_count = shadow_count + occ_t'(1);
        end
      end
      ACT_DEQ: begin
        if (shadow_count == '0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.word_out = shadow_slot[shadow_head];
          shadow_head = shadow_head + idx_t'(1);
          shadow_count = shadow_count - occ_t'(1);
        end
      end
      ACT_REV: begin
        if (it.prefix_len == '0 || it.prefix_len > shadow_count) begin
          r.status = ST_BAD_LEN;
        end else begin
          lo = 0;
          hi = int'(it.prefix_len) - 1;
          // index sums wrap at the slot width
          while (lo < hi) begin
            a = shadow_head + idx_t'(lo);
            b = shadow_head + idx_t'(hi);
            t = shadow_slot[a];
            shadow_slot[a] = shadow_slot[b];
            shadow_slot[b] = t;
            lo++;
            hi--;
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy_out = shadow_count;
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hFFFFFFFF;
      default: return word_t'($urandom);
    endcase
  endfunction

  // reverse length in range, mostly short
  function automatic logic [8:0] rand_good_len();
    int top;
    top = int'(shadow_count);
    if (top > 16 && $urandom_range(0, 3) != 0) begin
      top = 16;
    end
    return 9'($urandom_range(1, top));
  endfunction

  function automatic in_item_t pick_mixed_action();
    in_item_t it;
    int pick;
    it.action = ACT_ENQ;
    it.word_in = word_t'($urandom);
    it.prefix_len = 9'($urandom_range(0, 511));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.word_in = rand_word();
    end else if (pick < 80) begin
      it.action = ACT_DEQ;
    end else if (pick < 95) begin
      it.action = ACT_REV;
      if (shadow_count != '0) begin
        it.prefix_len = rand_good_len();
      end
    end else if (pick < 98) begin
      it.action = ACT_REV;
      if ($urandom_range(0, 1) == 0) begin
        it.prefix_len = '0;
      end else begin
        it.prefix_len = 9'($urandom_range(int'(shadow_count) + 1, 511));
      end
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // offers one item, waits for the transfer, then records the reply it should give
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t reply);
    int gap;
    out_item_t r;
    if (sent_count % 50 == 0) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
    end
    gap = tx_idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    r = apply_action(it);
    queue_replies.push_back(typed ? reply : r);
    sent_count++;
  endtask

  task automatic fill_and_drain();
    in_item_t it;
    it = '0;
    while (shadow_count != occ_t'(DEPTH)) begin
      it.action = ACT_ENQ;
      it.word_in = rand_word();
      it.prefix_len = 9'($urandom_range(0, 511));
      send_item(it, 1'b0, NO_REPLY);
    end
    // writes into a full queue are dropped
    repeat (3) begin
      it.action = ACT_ENQ;
      it.word_in = rand_word();
      send_item(it, 1'b0, NO_REPLY);
    end
    it.action = ACT_REV;
    it.prefix_len = 9'(DEPTH);
    send_item(it, 1'b0, NO_REPLY);
    it.prefix_len = 9'(DEPTH + 1);
    send_item(it, 1'b0, NO_REPLY);
    it.prefix_len = 9'($urandom_range(2, DEPTH));
    send_item(it, 1'b0, NO_REPLY);
    while (shadow_count != '0) begin
      it.word_in = word_t'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        it.action = ACT_REV;
        it.prefix_len = rand_good_len();
      end else begin
        it.action = ACT_DEQ;
      end
      send_item(it, 1'b0, NO_REPLY);
    end
    it.action = ACT_DEQ;
    repeat (2) send_item(it, 1'b0, NO_REPLY);
  endtask

  // result side: random stalls, one long hold-off, field-by-field compare
  initial begin
    int stall;
    int taken;
    int rx_idle_on;
    out_item_t want;
    taken = 0;
    rx_idle_on = 1;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 50 == 0) begin
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      stall = rx_idle_on ? $urandom_range(0, 13) : 0;
      if (taken == HOLD_AT_RESULT) begin
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (queue_replies.size() == 0) begin
        report_mismatch("result with nothing pending, occupancy",
                        32'(out_data.occupancy_out), 32'd0);
      end else begin
        want = queue_replies.pop_front();
        if (out_data.word_out !== want.word_out) begin
          report_mismatch("word_out", out_data.word_out, want.word_out);
        end
        if (out_data.status !== want.status) begin
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        end
        if (out_data.occupancy_out !== want.occupancy_out) begin
          report_mismatch("occupancy_out", 32'(out_data.occupancy_out),
                          32'(want.occupancy_out));
        end
      end
    end
  end

  // ends the run when no transfer happens for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("circular_queue_reverse_prefix regression: fail");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (stim_table[i]) begin
      send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].reply);
    end
    repeat (300) send_item(pick_mixed_action(), 1'b0, NO_REPLY);
    fill_and_drain();
    repeat (300) send_item(pick_mixed_action(), 1'b0, NO_REPLY);
    fill_and_drain();
    in_valid <= 1'b0;
    while (queue_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && queue_replies.size() == 0) begin
      $display("circular_queue_reverse_prefix regression: pass");
    end else begin
      $display("circular_queue_reverse_prefix regression: fail");
    end
    $finish;
  end

endmodule
